// ===== rtl/ctd_pkg.sv =====
`default_nettype none

package ctd_pkg;

  // Default build: five samples per measurement from a 10-bit converter.
  localparam int DEF_SAMPLES_PER_MEASUREMENT = 5;
  localparam int DEF_ADC_BITS = 10;

  // Fixed widths of the ports and configuration registers.
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W = 10;
  localparam int THRESH_W = 10;
  localparam int COUNT_W = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int STATUS_W = 2;

  // Register reset values.
  localparam logic [THRESH_W-1:0] PRE_FULL_THRESHOLD_RST = THRESH_W'(388);
  localparam logic [THRESH_W-1:0] FULL_THRESHOLD_RST = THRESH_W'(250);
  localparam logic [COUNT_W-1:0] PRE_FULL_COUNT_RST = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] FULL_COUNT_RST = COUNT_W'(3);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRE_FULL_THRESHOLD = 3'd0,
    CFG_FULL_THRESHOLD = 3'd1,
    CFG_PRE_FULL_COUNT = 3'd2,
    CFG_FULL_COUNT = 3'd3,
    CFG_FULL_NEEDS_PRE = 3'd4
  } cfg_index_t;

  localparam logic [STATUS_W-1:0] STATUS_NOT_FULL = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PRE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAILED = 2'd3;

  typedef struct packed {
    logic [THRESH_W-1:0] pre_full_threshold;
    logic [THRESH_W-1:0] full_threshold;
    logic [COUNT_W-1:0] pre_full_count;
    logic [COUNT_W-1:0] full_count;
    logic full_needs_pre;
  } ctd_cfg_t;

  // What the measurement side tells the detection side about the current item.
  typedef struct packed {
    logic charger_present;
    logic sample_failed;
    logic done;
    logic charging_on;
  } ctd_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/charge_termination_detector.sv =====
// Charge termination detector.
//
// Input channel (in_valid / in_stall): one converter sample per item with its
// failed flag and the charger and charging status. An item is taken at a rising
// edge with in_valid high and in_stall low; it lands in an input register.
// Output channel (out_valid / out_stall): status and current_level. A result is
// made when a group of samples completes, when a sample fails, or when the
// charger is absent; the other items update the running measurement only.
// A result appears on out_valid at the edge at which its item leaves the
// input register. Throughput is one item per cycle while no result is held
// by out_stall; the min, max and sum update and the reciprocal multiply for
// the trimmed mean are both combinational between the two registers.
// When out_stall holds a result, the next item waits in the input register and
// in_stall rises once that register is occupied. Results are never dropped.
// Synchronous reset empties both registers, clears the measurement and the
// pre-full and full detection, and loads the threshold and count registers with
// their defaults. Configuration writes (cfg_write, cfg_index, cfg_data) take
// effect at the next edge and belong to idle periods only.
`default_nettype none

module charge_termination_detector #(
  parameter int SAMPLES_PER_MEASUREMENT = ctd_pkg::DEF_SAMPLES_PER_MEASUREMENT,
  parameter int ADC_BITS = ctd_pkg::DEF_ADC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [ctd_pkg::SAMPLE_W-1:0] sample,
  input  logic sample_failed,
  input  logic charger_present,
  input  logic charging_on,
  output logic out_valid,
  input  logic out_stall,
  output logic [ctd_pkg::STATUS_W-1:0] status,
  output logic [ctd_pkg::LEVEL_W-1:0] current_level,
  input  logic cfg_write,
  input  logic [ctd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctd_pkg::*;

  ctd_cfg_t cfg;

  logic in_full;
  logic [SAMPLE_W-1:0] sample_q;
  logic failed_q;
  logic present_q;
  logic charging_q;

  logic accept;
  logic advance;
  logic produce;
  logic done;
  logic [LEVEL_W-1:0] level;
  logic [STATUS_W-1:0] status_next;
  ctd_ctrl_t ctrl;

  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept = in_valid && !in_stall;
  assign produce = !present_q || failed_q || done;

  assign ctrl.charger_present = present_q;
  assign ctrl.sample_failed = failed_q;
  assign ctrl.done = done;
  assign ctrl.charging_on = charging_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_full_threshold <= PRE_FULL_THRESHOLD_RST;
      cfg.full_threshold <= FULL_THRESHOLD_RST;
      cfg.pre_full_count <= PRE_FULL_COUNT_RST;
      cfg.full_count <= FULL_COUNT_RST;
      cfg.full_needs_pre <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRE_FULL_THRESHOLD: cfg.pre_full_threshold <= cfg_data[THRESH_W-1:0];
        CFG_FULL_THRESHOLD:     cfg.full_threshold <= cfg_data[THRESH_W-1:0];
        CFG_PRE_FULL_COUNT:     cfg.pre_full_count <= cfg_data[COUNT_W-1:0];
        CFG_FULL_COUNT:         cfg.full_count <= cfg_data[COUNT_W-1:0];
        CFG_FULL_NEEDS_PRE:     cfg.full_needs_pre <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
      failed_q <= sample_failed;
      present_q <= charger_present;
      charging_q <= charging_on;
    end
  end

  ctd_measure #(
    .SAMPLES_PER_MEASUREMENT(SAMPLES_PER_MEASUREMENT),
    .ADC_BITS(ADC_BITS)
  ) u_measure (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .sample(sample_q),
    .sample_failed(failed_q),
    .charger_present(present_q),
    .done(done),
    .level(level)
  );

  ctd_debounce u_debounce (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .ctrl(ctrl),
    .level(level),
    .cfg(cfg),
    .status(status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      status <= status_next;
      current_level <= done ? level : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctd_measure.sv =====
`default_nettype none

module ctd_measure #(
  parameter int SAMPLES_PER_MEASUREMENT = ctd_pkg::DEF_SAMPLES_PER_MEASUREMENT,
  parameter int ADC_BITS = ctd_pkg::DEF_ADC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic [ctd_pkg::SAMPLE_W-1:0] sample,
  input  logic sample_failed,
  input  logic charger_present,
  output logic done,
  output logic [ctd_pkg::LEVEL_W-1:0] level
);
  import ctd_pkg::*;

  localparam int SAMP_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CNT_W = $clog2(SAMPLES_PER_MEASUREMENT);
  localparam int SUM_W = SAMP_W + CNT_W;
  localparam int DIVISOR = SAMPLES_PER_MEASUREMENT - 2;
  // With three extra fraction bits the rounded-up reciprocal gives the exact
  // truncated quotient for every sum that fits in SUM_W bits.
  localparam int FRAC_W = SUM_W + 3;
  localparam int RECIP_W = FRAC_W + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << FRAC_W) + DIVISOR - 1) / DIVISOR);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_MEASUREMENT - 1);

  logic [CNT_W-1:0] samples_taken;
  logic [SUM_W-1:0] running_sum;
  logic [SAMP_W-1:0] largest_seen;
  logic [SAMP_W-1:0] smallest_seen;

  logic [SAMP_W-1:0] s;
  logic [SAMP_W-1:0] largest_next;
  logic [SAMP_W-1:0] smallest_next;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] trimmed;
  logic [PROD_W-1:0] product;
  logic [SAMP_W-1:0] quotient;

  assign s = sample[SAMP_W-1:0];

  always_comb begin
    largest_next = (s > largest_seen) ? s : largest_seen;
    smallest_next = (s < smallest_seen) ? s : smallest_seen;
    sum_next = running_sum + SUM_W'(s);
    trimmed = sum_next - SUM_W'(largest_next) - SUM_W'(smallest_next);
    product = PROD_W'(trimmed) * PROD_W'(RECIP);
    quotient = product[FRAC_W +: SAMP_W];
    done = charger_present && !sample_failed && (samples_taken == LAST);
    level = LEVEL_W'(quotient);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_taken <= '0;
      running_sum <= '0;
      largest_seen <= '0;
      smallest_seen <= '1;
    end else if (step) begin
      if (!charger_present || sample_failed || done) begin
        samples_taken <= '0;
        running_sum <= '0;
        largest_seen <= '0;
        smallest_seen <= '1;
      end else begin
        samples_taken <= samples_taken + 1'b1;
        running_sum <= sum_next;
        largest_seen <= largest_next;
        smallest_seen <= smallest_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctd_debounce.sv =====
`default_nettype none

module ctd_debounce (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  ctd_pkg::ctd_ctrl_t ctrl,
  input  logic [ctd_pkg::LEVEL_W-1:0] level,
  input  ctd_pkg::ctd_cfg_t cfg,
  output logic [ctd_pkg::STATUS_W-1:0] status
);
  import ctd_pkg::*;

  logic pre_full_flag;
  logic full_flag;
  logic [COUNT_W-1:0] pre_full_run;
  logic [COUNT_W-1:0] full_run;

  logic pre_full_flag_next;
  logic full_flag_next;
  logic [COUNT_W-1:0] pre_full_run_next;
  logic [COUNT_W-1:0] full_run_next;

  always_comb begin
    pre_full_flag_next = pre_full_flag;
    full_flag_next = full_flag;
    pre_full_run_next = pre_full_run;
    full_run_next = full_run;

    if (!ctrl.charger_present) begin
      pre_full_flag_next = 1'b0;
      full_flag_next = 1'b0;
      pre_full_run_next = '0;
      full_run_next = '0;
    end else if (!ctrl.sample_failed && ctrl.done) begin
      if (!ctrl.charging_on) begin
        pre_full_flag_next = 1'b0;
        full_flag_next = 1'b0;
        pre_full_run_next = '0;
        full_run_next = '0;
      end else begin
        // The pre-full run must be unbroken; any other level restarts it.
        if (!pre_full_flag && (level < cfg.pre_full_threshold)) begin
          if (pre_full_run >= cfg.pre_full_count) begin
            pre_full_flag_next = 1'b1;
          end else begin
            pre_full_run_next = pre_full_run + 1'b1;
          end
        end else begin
          pre_full_run_next = '0;
        end

        // The full stage sees a pre-full flag set by this same measurement.
        if (!full_flag && (!cfg.full_needs_pre || pre_full_flag_next) &&
            (level < cfg.full_threshold)) begin
          if (full_run >= cfg.full_count) begin
            full_flag_next = 1'b1;
          end else begin
            full_run_next = full_run + 1'b1;
          end
        end
      end
    end

    if (!ctrl.charger_present) begin
      status = STATUS_NOT_FULL;
    end else if (ctrl.sample_failed) begin
      status = STATUS_FAILED;
    end else if (full_flag_next) begin
      status = STATUS_FULL;
    end else if (pre_full_flag_next) begin
      status = STATUS_PRE_FULL;
    end else begin
      status = STATUS_NOT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_full_flag <= 1'b0;
      full_flag <= 1'b0;
      pre_full_run <= '0;
      full_run <= '0;
    end else if (step) begin
      pre_full_flag <= pre_full_flag_next;
      full_flag <= full_flag_next;
      pre_full_run <= pre_full_run_next;
      full_run <= full_run_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctd_checker.sv =====
`default_nettype none

module ctd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [ctd_pkg::STATUS_W-1:0] status,
  input logic [ctd_pkg::LEVEL_W-1:0] current_level
);
  import ctd_pkg::*;

  // Both registers are empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_stall))
    else $error("block not empty after reset");

  // With no result waiting the input side never stalls.
  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  // A failed measurement carries no level.
  a_failed_level_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_FAILED) |-> current_level == '0)
    else $error("failed item reported a nonzero level");

  // A held result stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(current_level)))
    else $error("stalled result changed");

  // An offered item is held off only while the receiver holds a result back.
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |-> (out_valid && out_stall))
    else $error("input stalled with no held result");

endmodule

bind charge_termination_detector ctd_checker u_ctd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status(status),
  .current_level(current_level)
);

`default_nettype wire

// ===== tb/charge_termination_detector_test.sv =====
module charge_termination_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctd_pkg::*;

  localparam int SAMPLES = DEF_SAMPLES_PER_MEASUREMENT;
  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << DEF_ADC_BITS) - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam int RANDOM_ITEMS = 1900;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int LIMIT_NS = 12_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0] level;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic sample_failed = 1'b0;
  logic charger_present = 1'b0;
  logic charging_on = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0] current_level;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the registers and of the detector state.
  logic [THRESH_W-1:0] pre_thr = PRE_FULL_THRESHOLD_RST;
  logic [THRESH_W-1:0] full_thr = FULL_THRESHOLD_RST;
  logic [COUNT_W-1:0] pre_cnt = PRE_FULL_COUNT_RST;
  logic [COUNT_W-1:0] full_cnt = FULL_COUNT_RST;
  logic needs_pre = 1'b0;
  int unsigned grp_taken = 0;
  int unsigned grp_sum = 0;
  logic [SAMPLE_W-1:0] grp_max = '0;
  logic [SAMPLE_W-1:0] grp_min = ADC_MASK;
  logic pre_flag = 1'b0;
  logic full_flag = 1'b0;
  logic [COUNT_W-1:0] pre_run = '0;
  logic [COUNT_W-1:0] full_run = '0;

  reading_t readings_due[$];
  int err_count = 0;
  int items_sent = 0;
  int readings_seen = 0;
  int settings_used = 1;
  int status_seen[4] = '{0, 0, 0, 0};
  bit steady = 1'b0;

  charge_termination_detector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .sample_failed(sample_failed),
    .charger_present(charger_present),
    .charging_on(charging_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .current_level(current_level),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_group();
    grp_taken = 0;
    grp_sum = 0;
    grp_max = '0;
    grp_min = ADC_MASK;
  endfunction

  function automatic void clear_detect();
    pre_flag = 1'b0;
    full_flag = 1'b0;
    pre_run = '0;
    full_run = '0;
  endfunction

  function automatic void compute_reading(logic [SAMPLE_W-1:0] smp, logic failed,
                                          logic present, logic charging);
    logic [SAMPLE_W-1:0] s;
    int unsigned level;
    reading_t r;
    s = smp & ADC_MASK;
    r.status = STATUS_NOT_FULL;
    r.level = '0;
    if (!present) begin
      clear_group();
      clear_detect();
      readings_due.push_back(r);
    end else if (failed) begin
      // The partial group is lost but the debounce state survives.
      clear_group();
      r.status = STATUS_FAILED;
      readings_due.push_back(r);
    end else begin
      if (s > grp_max) grp_max = s;
      if (s < grp_min) grp_min = s;
      grp_sum += s;
      grp_taken++;
      if (grp_taken == SAMPLES) begin
        level = (grp_sum - grp_max - grp_min) / (SAMPLES - 2);
        clear_group();
        if (!charging) begin
          clear_detect();
        end else begin
          if (!pre_flag && level < pre_thr) begin
            if (pre_run >= pre_cnt) pre_flag = 1'b1;
            else pre_run++;
          end else begin
            pre_run = '0;
          end
          // The full stage sees a pre-full flag set by this same measurement.
          if (!full_flag && (!needs_pre || pre_flag) && level < full_thr) begin
            if (full_run >= full_cnt) full_flag = 1'b1;
            else full_run++;
          end
        end
        r.status = full_flag ? STATUS_FULL : (pre_flag ? STATUS_PRE_FULL : STATUS_NOT_FULL);
        r.level = LEVEL_W'(level);
        readings_due.push_back(r);
      end
    end
  endfunction

  task automatic send_item(logic [SAMPLE_W-1:0] smp, logic failed, logic present,
                           logic charging);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= smp;
    sample_failed <= failed;
    charger_present <= present;
    charging_on <= charging;
    do @(posedge clk); while (in_stall);
    compute_reading(smp, failed, present, charging);
    items_sent++;
  endtask

  task automatic send_level(logic [SAMPLE_W-1:0] smp, logic charging);
    repeat (SAMPLES) send_item(smp, 1'b0, 1'b1, charging);
  endtask

  // Holds the sender off until every awaited reading is in, then lets the
  // pipeline empty of items that produce none.
  task automatic wait_drained();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (readings_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (readings_due.size() != 0) begin
      flag_error($sformatf("%0d readings never arrived", readings_due.size()));
      readings_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (cfg_index_t'(idx))
      CFG_PRE_FULL_THRESHOLD: pre_thr = data[THRESH_W-1:0];
      CFG_FULL_THRESHOLD: full_thr = data[THRESH_W-1:0];
      CFG_PRE_FULL_COUNT: pre_cnt = data[COUNT_W-1:0];
      CFG_FULL_COUNT: full_cnt = data[COUNT_W-1:0];
      CFG_FULL_NEEDS_PRE: needs_pre = data[0];
      default: ;
    endcase
  endtask

  // Unused upper data bits are filled at random; a spare index is written too.
  task automatic apply_settings(int pthr, int fthr, int pcnt, int fcnt, int needs);
    wait_drained();
    write_reg(CFG_PRE_FULL_THRESHOLD, CFG_DATA_W'(pthr));
    write_reg(CFG_FULL_THRESHOLD, CFG_DATA_W'(fthr));
    write_reg(CFG_PRE_FULL_COUNT, {2'($urandom), COUNT_W'(pcnt)});
    write_reg(CFG_FULL_COUNT, {2'($urandom), COUNT_W'(fcnt)});
    write_reg(CFG_FULL_NEEDS_PRE, {9'($urandom), 1'(needs)});
    write_reg(CFG_INDEX_W'(CFG_SPARE_FIRST + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  task automatic test_extremes();
    send_item('0, 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_MAX, 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_MAX, 1'b0, 1'b1, 1'b1);
    send_item('0, 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_W'(512), 1'b0, 1'b1, 1'b1);
    send_level(SAMPLE_MAX, 1'b1);
  endtask

  task automatic test_sample_failed();
    send_item(SAMPLE_W'(100), 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_W'(200), 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_MAX, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_charger_absent();
    send_item(SAMPLE_W'(5), 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_MAX, 1'b1, 1'b0, 1'b1);
  endtask

  // Only the last sample of a group decides whether charging is on.
  task automatic test_not_charging();
    repeat (SAMPLES - 1) send_item(SAMPLE_W'(20), 1'b0, 1'b1, 1'b1);
    send_item(SAMPLE_W'(20), 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_same_measurement();
    apply_settings(500, 400, 0, 0, 1);
    send_level(SAMPLE_W'(30), 1'b1);
  endtask

  task automatic test_random_settings();
    int phase, sent_here, base, v, slot, roll;
    logic charging;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(PRE_FULL_THRESHOLD_RST, FULL_THRESHOLD_RST,
                          PRE_FULL_COUNT_RST, FULL_COUNT_RST, 1);
        1: apply_settings(0, 0, 0, 0, 0);
        2: apply_settings(1023, 1023, 255, 255, 1);
        3: apply_settings(1023, 1023, 0, 0, 1);
        4: apply_settings(600, 300, 1, 5, 0);
        default: apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 8), $urandom_range(0, 8),
                                $urandom_range(0, 1));
      endcase
      steady = (phase == 4);
      sent_here = 0;
      while (sent_here < RANDOM_ITEMS / RANDOM_PHASES) begin
        // Each group clusters around a level chosen relative to the thresholds.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: base = (pre_thr == 0) ? 0 : $urandom_range(0, pre_thr - 1);
          4, 5, 6: base = (full_thr == 0) ? 0 : $urandom_range(0, full_thr - 1);
          7: base = $urandom_range(pre_thr, 1023);
          default: base = $urandom_range(0, 1023);
        endcase
        charging = ($urandom_range(0, 19) != 0);
        for (slot = 0; slot < SAMPLES; slot++) begin
          roll = $urandom_range(0, 99);
          if (roll < 2) begin
            send_item(SAMPLE_W'($urandom), 1'($urandom), 1'b0, 1'($urandom));
          end else if (roll < 5) begin
            send_item(SAMPLE_W'($urandom), 1'b1, 1'b1, 1'($urandom));
          end else begin
            v = base + int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? 1023 : 0;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            send_item(SAMPLE_W'(v), 1'b0, 1'b1, charging);
          end
          sent_here++;
          if ($urandom_range(0, 199) == 0) wait_drained();
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      readings_seen++;
      status_seen[status]++;
      if (readings_due.size() == 0) begin
        flag_error($sformatf("unexpected reading: status %0d level %0d",
                             status, current_level));
      end else begin
        want = readings_due.pop_front();
        if (status !== want.status) begin
          flag_error($sformatf("status: expected %0d, got %0d", want.status, status));
        end
        if (current_level !== want.level) begin
          flag_error($sformatf("current_level: expected %0d, got %0d",
                               want.level, current_level));
        end
      end
    end
  end

  // The receiver passes for a while, then may stall for a random stretch.
  initial begin : stall_driver
    int pass_len, hold;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      pass_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 20);
      out_stall <= 1'b0;
      repeat (pass_len) @(posedge clk);
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timeout: readings still awaited: %0d", readings_due.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_sample_failed();
    test_charger_absent();
    test_not_charging();
    test_same_measurement();
    test_random_settings();
    wait_drained();
    $display("Sent %0d items under %0d register settings; %0d readings checked.",
             items_sent, settings_used, readings_seen);
    $display("Readings by status: not full %0d, pre-full %0d, full %0d, failed %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Errors: %0d", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== charge_termination_detector.f =====
rtl/ctd_pkg.sv
rtl/ctd_measure.sv
rtl/ctd_debounce.sv
rtl/charge_termination_detector.sv
rtl/ctd_checker.sv
tb/charge_termination_detector_test.sv
